>>> design/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg: shared types, constants and tap tables of the circular LBP core
// Sample geometry (radius 1, eight samples), bilinear weights as 33-bit
// fractions of 2^32, the column entry carried between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package clbp_pkg;

    localparam int RADIUS     = 1;
    localparam int NEIGHBORS  = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int LINES      = 2 * RADIUS;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LINE_SEL_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CODE_W      = 8;

    localparam int WEIGHT_W = 33;
    localparam int DIFF_W   = PIX_W + 1;
    localparam int PROD_W   = WEIGHT_W + 1 + DIFF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int TOL_Q32  = 512;
    localparam int CORNERS  = 4;

    localparam int LINE_WIDTH_RESET   = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } reg_index_t;

    // Floor and ceiling offsets and the 16-bit fraction of every sample.
    localparam int TAP_FX [NEIGHBORS] = '{0, -1, -1, -1, 0, 0, 1, 0};
    localparam int TAP_CX [NEIGHBORS] = '{0, 0, -1, 0, 0, 1, 1, 1};
    localparam int TAP_TX [NEIGHBORS] = '{0, 19195, 0, 19195, 0, 46341, 0, 46341};
    localparam int TAP_FY [NEIGHBORS] = '{1, 0, 0, -1, -1, -1, 0, 0};
    localparam int TAP_CY [NEIGHBORS] = '{1, 1, 0, 0, -1, 0, 0, 1};
    localparam int TAP_TY [NEIGHBORS] = '{0, 46341, 0, 19195, 0, 19195, 0, 46341};

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic             produce;
        logic             row_last;
        logic             frame_last;
    } col_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Corner bit 0 picks the ceiling column, bit 1 the ceiling row.
    function automatic int tap_row(input int n, input int q);
        return RADIUS + (((q & 2) != 0) ? TAP_CY[n] : TAP_FY[n]);
    endfunction

    function automatic int tap_col(input int n, input int q);
        return RADIUS + (((q & 1) != 0) ? TAP_CX[n] : TAP_FX[n]);
    endfunction

    function automatic logic [WEIGHT_W-1:0] tap_weight(input int n, input int q);
        longint wx;
        longint wy;
        wx = ((q & 1) != 0) ? longint'(TAP_TX[n]) : 64'sd65536 - longint'(TAP_TX[n]);
        wy = ((q & 2) != 0) ? longint'(TAP_TY[n]) : 64'sd65536 - longint'(TAP_TY[n]);
        return WEIGHT_W'(wx * wy);
    endfunction

    // Last valid index for a size register, after clamping to [WIN, hi].
    function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                    input int hi);
        logic [CFG_W-1:0] r;
        if (v < CFG_W'(WIN)) begin
            r = CFG_W'(WIN - 1);
        end else if (v > CFG_W'(hi)) begin
            r = CFG_W'(hi - 1);
        end else begin
            r = v - CFG_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/clbp_front.sv
// ----------------------------------------------------------------------------
// clbp_front: pixel intake, position counters and line buffers
// Tracks row and column, reads the stored rows above each pixel, writes the
// pixel back, and hands a classified window column to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [clbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [clbp_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [clbp_pkg::PIX_W-1:0]       s_pixel,
    input  wire logic                             s_frame_start,
    output logic                                  push,
    output clbp_pkg::col_entry_t                  push_entry,
    input  wire clbp_pkg::q_status_t              q_status,
    output logic                                  clear_busy
);

    logic [clbp_pkg::COL_W-1:0] col_reg, col_next;
    logic [clbp_pkg::ROW_W-1:0] row_reg, row_next;
    logic [clbp_pkg::COL_W-1:0] line_last_reg, line_last_next;
    logic [clbp_pkg::ROW_W-1:0] row_last_reg, row_last_next;
    logic [clbp_pkg::COL_W-1:0] clr_addr_reg;
    logic                       clr_busy_reg;

    logic                            f_valid_reg;
    logic [clbp_pkg::PIX_W-1:0]      f_pix_reg;
    logic [clbp_pkg::LINE_SEL_W-1:0] f_sel_reg;
    logic                            f_produce_reg;
    logic                            f_row_last_reg;
    logic                            f_frame_last_reg;

    logic [clbp_pkg::PIX_W-1:0] line_mem [clbp_pkg::LINES][clbp_pkg::MAX_WIDTH];
    logic [clbp_pkg::PIX_W-1:0] rd_reg [clbp_pkg::LINES];

    logic                            accept;
    logic [clbp_pkg::COL_W-1:0]      col_cur;
    logic [clbp_pkg::ROW_W-1:0]      row_cur;
    logic [clbp_pkg::LINE_SEL_W-1:0] sel_cur;
    logic                            col_end;
    logic                            row_end;
    logic                            produce_cur;

    assign s_ready    = !clr_busy_reg && (!f_valid_reg || !q_status.full);
    assign accept     = s_valid && s_ready;
    assign push       = f_valid_reg && !q_status.full;
    assign clear_busy = clr_busy_reg;

    always_comb begin
        col_cur     = s_frame_start ? '0 : col_reg;
        row_cur     = s_frame_start ? '0 : row_reg;
        sel_cur     = row_cur[clbp_pkg::LINE_SEL_W-1:0];
        col_end     = col_cur >= line_last_reg;
        row_end     = row_cur >= row_last_reg;
        produce_cur = (col_cur >= clbp_pkg::COL_W'(clbp_pkg::LINES)) &&
                      (row_cur >= clbp_pkg::ROW_W'(clbp_pkg::LINES));
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_cur + clbp_pkg::ROW_W'(1);
            end else begin
                col_next = col_cur + clbp_pkg::COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_comb begin
        line_last_next = line_last_reg;
        row_last_next  = row_last_reg;
        if (cfg_we && cfg_index == clbp_pkg::REG_LINE_WIDTH) begin
            line_last_next = clbp_pkg::COL_W'(
                clbp_pkg::last_index(cfg_data, clbp_pkg::MAX_WIDTH));
        end
        if (cfg_we && cfg_index == clbp_pkg::REG_FRAME_HEIGHT) begin
            row_last_next = clbp_pkg::ROW_W'(
                clbp_pkg::last_index(cfg_data, clbp_pkg::MAX_HEIGHT));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            line_last_reg <= clbp_pkg::COL_W'(clbp_pkg::last_index(
                clbp_pkg::CFG_W'(clbp_pkg::LINE_WIDTH_RESET), clbp_pkg::MAX_WIDTH));
            row_last_reg  <= clbp_pkg::ROW_W'(clbp_pkg::last_index(
                clbp_pkg::CFG_W'(clbp_pkg::FRAME_HEIGHT_RESET), clbp_pkg::MAX_HEIGHT));
            clr_addr_reg  <= '0;
            clr_busy_reg  <= 1'b1;
            f_valid_reg   <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            line_last_reg <= line_last_next;
            row_last_reg  <= row_last_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + clbp_pkg::COL_W'(1);
                if (clr_addr_reg == clbp_pkg::COL_W'(clbp_pkg::MAX_WIDTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                f_valid_reg <= 1'b1;
            end else if (push) begin
                f_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_pix_reg        <= s_pixel;
            f_sel_reg        <= sel_cur;
            f_produce_reg    <= produce_cur;
            f_row_last_reg   <= col_end;
            f_frame_last_reg <= col_end && row_end;
        end
    end

    // The read returns the row stored before this pixel overwrites it.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < clbp_pkg::LINES; k++) begin
            if (clr_busy_reg) begin
                line_mem[k][clr_addr_reg] <= '0;
            end else if (accept && sel_cur == clbp_pkg::LINE_SEL_W'(k)) begin
                line_mem[k][col_cur] <= s_pixel;
            end
            if (accept) begin
                rd_reg[k] <= line_mem[k][col_cur];
            end
        end
    end

    // The buffer of the current row parity holds the oldest row.
    always_comb begin
        push_entry.top        = rd_reg[f_sel_reg];
        push_entry.mid        = rd_reg[~f_sel_reg];
        push_entry.bot        = f_pix_reg;
        push_entry.produce    = f_produce_reg;
        push_entry.row_last   = f_row_last_reg;
        push_entry.frame_last = f_frame_last_reg;
    end

endmodule

`default_nettype wire

>>> design/clbp_queue.sv
// ----------------------------------------------------------------------------
// clbp_queue: short column queue between front and back
// A small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire clbp_pkg::col_entry_t push_entry,
    input  wire logic                 pop,
    output clbp_pkg::col_entry_t      head_entry,
    output clbp_pkg::q_status_t       q_status
);

    clbp_pkg::col_entry_t        slot_reg [clbp_pkg::QUEUE_DEPTH];
    logic [clbp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [clbp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [clbp_pkg::QCNT_W-1:0] count_reg;

    assign q_status.full  = count_reg == clbp_pkg::QCNT_W'(clbp_pkg::QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign head_entry     = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + clbp_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + clbp_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + clbp_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - clbp_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> design/clbp_back.sv
// ----------------------------------------------------------------------------
// clbp_back: sliding window and interpolated threshold pipeline
// Shifts each column into the 3x3 window, forms weighted differences to the
// centre for every sample corner, then sums and thresholds them.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire clbp_pkg::q_status_t         q_status,
    input  wire clbp_pkg::col_entry_t        head_entry,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [clbp_pkg::CODE_W-1:0]      m_lbp_code,
    output logic                             m_row_last,
    output logic                             m_frame_last
);

    logic [clbp_pkg::PIX_W-1:0] win_reg [clbp_pkg::WIN][clbp_pkg::WIN];
    logic                       b0_valid_reg;
    logic                       b0_row_last_reg;
    logic                       b0_frame_last_reg;

    logic signed [clbp_pkg::PROD_W-1:0]
        prod_reg  [clbp_pkg::NEIGHBORS][clbp_pkg::CORNERS],
        prod_next [clbp_pkg::NEIGHBORS][clbp_pkg::CORNERS];
    logic b1_valid_reg;
    logic b1_row_last_reg;
    logic b1_frame_last_reg;

    logic                        out_valid_reg;
    logic [clbp_pkg::CODE_W-1:0] code_reg, code_next;
    logic                        out_row_last_reg;
    logic                        out_frame_last_reg;

    logic advance;

    // The whole pipeline moves together; only a held result stops it.
    assign advance      = !out_valid_reg || m_ready;
    assign pop          = advance && !q_status.empty;
    assign m_valid      = out_valid_reg;
    assign m_lbp_code   = code_reg;
    assign m_row_last   = out_row_last_reg;
    assign m_frame_last = out_frame_last_reg;

    always_comb begin
        logic signed [clbp_pkg::DIFF_W-1:0] diff;
        logic        [clbp_pkg::PIX_W-1:0]  centre;
        centre = win_reg[clbp_pkg::RADIUS][clbp_pkg::RADIUS];
        for (int n = 0; n < clbp_pkg::NEIGHBORS; n++) begin
            for (int q = 0; q < clbp_pkg::CORNERS; q++) begin
                diff = $signed({1'b0, win_reg[clbp_pkg::tap_row(n, q)]
                                             [clbp_pkg::tap_col(n, q)]})
                     - $signed({1'b0, centre});
                prod_next[n][q] = $signed({1'b0, clbp_pkg::tap_weight(n, q)}) * diff;
            end
        end
    end

    // Weights sum to one, so the sample is at least the centre exactly when
    // the weighted differences plus the tolerance stay above zero.
    always_comb begin
        logic signed [clbp_pkg::SUM_W-1:0] sum;
        code_next = '0;
        for (int n = 0; n < clbp_pkg::NEIGHBORS && n < clbp_pkg::CODE_W; n++) begin
            sum = clbp_pkg::SUM_W'(clbp_pkg::TOL_Q32);
            for (int q = 0; q < clbp_pkg::CORNERS; q++) begin
                sum = sum + clbp_pkg::SUM_W'(prod_reg[n][q]);
            end
            code_next[n] = !sum[clbp_pkg::SUM_W-1] && (sum != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            b0_valid_reg  <= pop && head_entry.produce;
            b1_valid_reg  <= b0_valid_reg;
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pop) begin
                for (int k = 0; k < clbp_pkg::WIN; k++) begin
                    for (int j = 0; j + 1 < clbp_pkg::WIN; j++) begin
                        win_reg[k][j] <= win_reg[k][j + 1];
                    end
                end
                win_reg[0][clbp_pkg::WIN - 1] <= head_entry.top;
                win_reg[1][clbp_pkg::WIN - 1] <= head_entry.mid;
                win_reg[2][clbp_pkg::WIN - 1] <= head_entry.bot;
                b0_row_last_reg   <= head_entry.row_last;
                b0_frame_last_reg <= head_entry.frame_last;
            end
            prod_reg           <= prod_next;
            b1_row_last_reg    <= b0_row_last_reg;
            b1_frame_last_reg  <= b0_frame_last_reg;
            code_reg           <= code_next;
            out_row_last_reg   <= b1_row_last_reg;
            out_frame_last_reg <= b1_frame_last_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/circular_lbp_operator_core.sv
// ----------------------------------------------------------------------------
// circular_lbp_operator_core: radius-1, eight-sample circular LBP on a stream
// Pixels enter in raster order on the s_ channel (valid/ready), one beat per
// pixel, with s_frame_start on the first pixel of a frame. For every pixel at
// row >= 2 and column >= 2 the m_ channel carries one beat with the code of
// the pixel one row up and one column left; border pixels give no beat.
// m_row_last marks the last code of a row, m_frame_last that of the frame.
// Line width and frame height are written through cfg_we/cfg_index/cfg_data
// while the block is idle; values are clamped to 3..1024.
// Throughput is one pixel per cycle while m_ready is high. An accepted pixel's
// code passes the line buffer read, the queue slot, the window register, the
// product stage, and the sum and threshold stage.
// After reset the line buffers are cleared, all 1024 columns at one column a
// cycle, and s_ready stays low meanwhile; configuration writes are still
// taken. When the receiver stalls, the held result blocks the back pipeline,
// the four-entry queue fills, and then s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_lbp_operator_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [clbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [clbp_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [clbp_pkg::PIX_W-1:0]       s_pixel,
    input  wire logic                             s_frame_start,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [clbp_pkg::CODE_W-1:0]           m_lbp_code,
    output logic                                  m_row_last,
    output logic                                  m_frame_last
);

    logic                 push;
    logic                 pop;
    logic                 clear_busy;
    clbp_pkg::col_entry_t push_entry;
    clbp_pkg::col_entry_t head_entry;
    clbp_pkg::q_status_t  q_status;

    clbp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .push          (push),
        .push_entry    (push_entry),
        .q_status      (q_status),
        .clear_busy    (clear_busy)
    );

    clbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    clbp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lbp_code   (m_lbp_code),
        .m_row_last   (m_row_last),
        .m_frame_last (m_frame_last)
    );

    // No pixel may enter while the line buffers are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_ready)
        else $error("pixel accepted during line buffer clear");

    // The queue cannot be full and empty at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // Nothing has entered before the clear ends, so no result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clear_busy) |-> !m_valid && q_status.empty)
        else $error("result present before any pixel was taken");

    // The queue never pops while empty or pushes while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_status.empty) && !(push && q_status.full))
        else $error("queue overrun or underrun");

endmodule

`default_nettype wire
